// ----- rtl/core/chorus_modulated_delay_assert.svh -----
// assertion macros for the chorus delay block
// they sample on i_clk and stay quiet while i_rst_n is low
`ifndef CHORUS_MODULATED_DELAY_ASSERT_SVH
`define CHORUS_MODULATED_DELAY_ASSERT_SVH

// cons must hold in the same cycle as ante
`define CHMD_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// cons must hold in the cycle after ante
`define CHMD_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/chmd_pkg.sv -----
`default_nettype none

package chmd_pkg;

    // register reset values
    localparam logic [31:0] PHASE_STEP_RST = 32'd146087;
    localparam logic [10:0] BASE_DELAY_RST = 11'd1024;
    localparam logic [9:0]  DEPTH_RST      = 10'd88;

    // default sizes
    localparam int BUFFER_DEPTH_DEF = 2048;
    localparam int SINE_ENTRIES_DEF = 256;

    // output queue, must be deeper than the pipeline
    localparam int QUEUE_DEPTH = 8;
    localparam int QAW         = $clog2(QUEUE_DEPTH);
    localparam int QCW         = $clog2(QUEUE_DEPTH + 1);

    // fixed point constants for the sine table
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] ONE_Q30     = 64'd1073741824;

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_PHASE_STEP = 2'd0,
        CFG_BASE_DELAY = 2'd1,
        CFG_DEPTH      = 2'd2
    } t_cfg_reg;

    // lfo stage to tap stage
    typedef struct packed {
        logic               valid;
        logic signed [15:0] dry;
        logic signed [11:0] swing;
    } t_lfo_word;

    // tap stage to output queue
    typedef struct packed {
        logic               valid;
        logic signed [15:0] sample;
    } t_mix_word;

    // output queue status
    typedef struct packed {
        logic [QCW-1:0] count;
        logic           empty;
    } t_q_status;

    // q1.15 sine of a 32 bit angle fraction, taylor series in q30
    function automatic logic signed [15:0] sine_q15(input logic [31:0] frac);
        logic [1:0]         quad;
        logic [63:0]        t;
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic signed [63:0] sum;
        logic [63:0]        q;
        quad = frac[31:30];
        t    = {34'd0, frac[29:0]};
        if (quad[0]) begin
            t = ONE_Q30 - t;
        end
        x    = (t * HALF_PI_Q30) >> 30;
        x2   = (x * x) >> 30;
        term = x;
        sum  = $signed(x);
        term = ((term * x2) >> 30) / 64'd6;
        sum  = sum - $signed(term);
        term = ((term * x2) >> 30) / 64'd20;
        sum  = sum + $signed(term);
        term = ((term * x2) >> 30) / 64'd42;
        sum  = sum - $signed(term);
        term = ((term * x2) >> 30) / 64'd72;
        sum  = sum + $signed(term);
        term = ((term * x2) >> 30) / 64'd110;
        sum  = sum - $signed(term);
        term = ((term * x2) >> 30) / 64'd156;
        sum  = sum + $signed(term);
        term = ((term * x2) >> 30) / 64'd210;
        sum  = sum - $signed(term);
        if (sum < 0) begin
            sum = 64'sd0;
        end
        q = ($unsigned(sum) + 64'd16384) >> 15;
        if (q > 64'd32767) begin
            q = 64'd32767;
        end
        if (quad[1]) begin
            q = 64'd0 - q;
        end
        return $signed(q[15:0]);
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/chorus_modulated_delay.sv -----
`default_nettype none

// Chorus: each 16-bit sample is mixed with one tap of a delay memory whose
// delay is base_delay plus a sine LFO times depth_samples, clamped to the
// buffer; the result is floor((dry + delayed) / 2). The block takes one word
// per clock cycle while o_stall is low; each sample passes through index,
// sine lookup, depth multiply, delay clamp, memory read/write and the output
// queue in that order. The delay memory does one read and one write per cycle.
// An 8-word output queue with credit counting keeps intake running while
// results wait, so o_stall rises only when 8 words are outstanding. No
// clearing pass after reset: slots not written since reset read as zero.
// Write registers only while no word is in flight.

`include "chorus_modulated_delay_assert.svh"

module chorus_modulated_delay #(
    parameter int BUFFER_DEPTH = chmd_pkg::BUFFER_DEPTH_DEF,
    parameter int SINE_ENTRIES = chmd_pkg::SINE_ENTRIES_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // input channel
    input  wire logic               i_valid,
    output wire logic               o_stall,
    input  wire logic signed [15:0] i_sample_in,
    // output channel
    output wire logic               o_valid,
    input  wire logic               i_stall,
    output wire logic signed [15:0] o_sample_out,
    // register writes
    input  wire logic               i_cfg_wr_en,
    input  wire logic [1:0]         i_cfg_index,
    input  wire logic [31:0]        i_cfg_data
);
    import chmd_pkg::*;

    logic [31:0]    r_phase_step;
    logic [10:0]    r_base_delay;
    logic [9:0]     r_depth;
    logic [QCW-1:0] r_credit;
    logic [QCW-1:0] n_credit;

    logic      w_accept;
    logic      w_pop;
    t_lfo_word w_lfo;
    t_mix_word w_mix;
    t_q_status w_qstat;

    // handshakes
    assign o_stall  = (r_credit == QCW'(QUEUE_DEPTH));
    assign w_accept = i_valid && !o_stall;
    assign o_valid  = !w_qstat.empty;
    assign w_pop    = o_valid && !i_stall;

    // register file
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_step <= PHASE_STEP_RST;
            r_base_delay <= BASE_DELAY_RST;
            r_depth      <= DEPTH_RST;
        end else if (i_cfg_wr_en) begin
            unique case (t_cfg_reg'(i_cfg_index))
                CFG_PHASE_STEP: r_phase_step <= i_cfg_data;
                CFG_BASE_DELAY: r_base_delay <= i_cfg_data[10:0];
                CFG_DEPTH:      r_depth      <= i_cfg_data[9:0];
                default: begin
                end
            endcase
        end
    end

    // words in the pipeline plus words in the queue
    always_comb begin
        n_credit = r_credit;
        if (w_accept && !w_pop) begin
            n_credit = r_credit + 1'b1;
        end else if (!w_accept && w_pop) begin
            n_credit = r_credit - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_credit <= '0;
        end else begin
            r_credit <= n_credit;
        end
    end

    chmd_lfo #(
        .SINE_ENTRIES (SINE_ENTRIES)
    ) u_lfo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (w_accept),
        .i_sample_in  (i_sample_in),
        .i_phase_step (r_phase_step),
        .i_depth      (r_depth),
        .o_word       (w_lfo)
    );

    chmd_tap #(
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) u_tap (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_word       (w_lfo),
        .i_base_delay (r_base_delay),
        .o_word       (w_mix)
    );

    chmd_outq u_outq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_word   (w_mix),
        .i_pop    (w_pop),
        .o_sample (o_sample_out),
        .o_status (w_qstat)
    );

    // checks
    `CHMD_ASSERT_IMP(a_queue_no_overflow, w_mix.valid, w_qstat.count < QCW'(QUEUE_DEPTH), "output queue overflow")
    `CHMD_ASSERT_IMP(a_credit_covers_queue, 1'b1, w_qstat.count <= r_credit, "credit below queue fill")
    `CHMD_ASSERT_NEXT(a_accept_takes_credit, w_accept && !w_pop, r_credit != '0, "accepted word holds no credit")

endmodule

`default_nettype wire

// ----- rtl/core/chmd_lfo.sv -----
`default_nettype none

module chmd_lfo #(
    parameter int SINE_ENTRIES = 256
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_accept,
    input  wire logic signed [15:0] i_sample_in,
    input  wire logic [31:0]        i_phase_step,
    input  wire logic [9:0]         i_depth,
    output chmd_pkg::t_lfo_word     o_word
);
    import chmd_pkg::*;

    localparam int IW = $clog2(SINE_ENTRIES);
    localparam int SW = $clog2(SINE_ENTRIES + 1);

    // sine rom built at elaboration
    logic signed [15:0] w_rom [SINE_ENTRIES];
    for (genvar k = 0; k < SINE_ENTRIES; k++) begin : g_rom
        localparam logic [63:0] FRAC = (64'(k) << 32) / 64'(SINE_ENTRIES);
        assign w_rom[k] = sine_q15(FRAC[31:0]);
    end

    logic [31:0]        r_phase;
    logic               r_a_valid;
    logic               r_b_valid;
    logic               r_c_valid;
    logic signed [15:0] r_a_dry;
    logic signed [15:0] r_b_dry;
    logic signed [15:0] r_c_dry;
    logic [IW-1:0]      r_a_idx;
    logic signed [15:0] r_b_sine;
    logic signed [26:0] r_c_prod;
    logic [32+SW-1:0]   w_idx_prod;
    logic signed [26:0] w_swing_prod;

    // table index from the phase before it advances
    assign w_idx_prod   = {{SW{1'b0}}, r_phase} * (32+SW)'(SINE_ENTRIES);
    assign w_swing_prod = $signed({{11{r_b_sine[15]}}, r_b_sine})
                        * $signed({17'd0, i_depth});

    // phase accumulator and stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= '0;
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
        end else begin
            if (i_accept) begin
                r_phase <= r_phase + i_phase_step;
            end
            r_a_valid <= i_accept;
            r_b_valid <= r_a_valid;
            r_c_valid <= r_b_valid;
        end
    end

    // index, table lookup, depth scaling
    always_ff @(posedge i_clk) begin
        r_a_dry  <= i_sample_in;
        r_a_idx  <= w_idx_prod[32 +: IW];
        r_b_dry  <= r_a_dry;
        r_b_sine <= w_rom[r_a_idx];
        r_c_dry  <= r_b_dry;
        r_c_prod <= w_swing_prod;
    end

    // floor of the product over 2^15
    assign o_word.valid = r_c_valid;
    assign o_word.dry   = r_c_dry;
    assign o_word.swing = r_c_prod[26:15];

endmodule

`default_nettype wire

// ----- rtl/core/chmd_tap.sv -----
`default_nettype none

module chmd_tap #(
    parameter int BUFFER_DEPTH = 2048
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire chmd_pkg::t_lfo_word i_word,
    input  wire logic [10:0]         i_base_delay,
    output chmd_pkg::t_mix_word      o_word
);
    import chmd_pkg::*;

    localparam int AW  = $clog2(BUFFER_DEPTH);
    localparam int DLW = ((AW + 1) > 13) ? (AW + 1) : 13;

    logic signed [15:0] r_mem [BUFFER_DEPTH];

    logic               r_d_valid;
    logic signed [15:0] r_d_dry;
    logic [AW-1:0]      r_d_delay;
    logic               r_e_valid;
    logic signed [15:0] r_e_dry;
    logic               r_e_live;
    logic signed [15:0] r_e_rdata;
    logic [AW-1:0]      r_wp;
    logic               r_full;

    logic signed [DLW-1:0] w_sum;
    logic [AW-1:0]         w_delay;
    logic [AW:0]           w_rd_ext;
    logic [AW-1:0]         w_rd;
    logic                  w_live;
    logic signed [15:0]    w_delayed;
    logic signed [16:0]    w_mix;

    // centre delay plus swing, clamped to the buffer
    assign w_sum = $signed({{(DLW-11){1'b0}}, i_base_delay})
                 + $signed({{(DLW-12){i_word.swing[11]}}, i_word.swing});

    always_comb begin
        if (w_sum[DLW-1]) begin
            w_delay = '0;
        end else if (w_sum > $signed(DLW'(BUFFER_DEPTH - 1))) begin
            w_delay = AW'(BUFFER_DEPTH - 1);
        end else begin
            w_delay = w_sum[AW-1:0];
        end
    end

    // read address behind the write pointer, wrapped
    always_comb begin
        if (r_wp >= r_d_delay) begin
            w_rd_ext = {1'b0, r_wp} - {1'b0, r_d_delay};
        end else begin
            w_rd_ext = {1'b0, r_wp} + (AW+1)'(BUFFER_DEPTH) - {1'b0, r_d_delay};
        end
    end
    assign w_rd = w_rd_ext[AW-1:0];

    // slots not yet written since reset read as zero
    assign w_live = r_full || ((r_d_delay != '0) && (r_d_delay <= r_wp));

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_valid <= 1'b0;
            r_e_valid <= 1'b0;
            r_wp      <= '0;
            r_full    <= 1'b0;
        end else begin
            r_d_valid <= i_word.valid;
            r_e_valid <= r_d_valid;
            if (r_d_valid) begin
                if (r_wp == AW'(BUFFER_DEPTH - 1)) begin
                    r_wp   <= '0;
                    r_full <= 1'b1;
                end else begin
                    r_wp <= r_wp + 1'b1;
                end
            end
        end
    end

    // pipeline payload
    always_ff @(posedge i_clk) begin
        r_d_dry   <= i_word.dry;
        r_d_delay <= w_delay;
        r_e_dry   <= r_d_dry;
        r_e_live  <= w_live;
    end

    // delay memory, read before write on the same slot
    always_ff @(posedge i_clk) begin
        if (r_d_valid) begin
            r_e_rdata   <= r_mem[w_rd];
            r_mem[r_wp] <= r_d_dry;
        end
    end

    // half of dry plus delayed, rounded toward minus infinity
    assign w_delayed = r_e_live ? r_e_rdata : 16'sd0;
    assign w_mix     = {r_e_dry[15], r_e_dry} + {w_delayed[15], w_delayed};

    assign o_word.valid  = r_e_valid;
    assign o_word.sample = w_mix[16:1];

endmodule

`default_nettype wire

// ----- rtl/core/chmd_outq.sv -----
`default_nettype none

module chmd_outq (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire chmd_pkg::t_mix_word i_word,
    input  wire logic                i_pop,
    output wire logic signed [15:0]  o_sample,
    output chmd_pkg::t_q_status      o_status
);
    import chmd_pkg::*;

    logic signed [15:0] r_q [QUEUE_DEPTH];
    logic [QAW-1:0]     r_wptr;
    logic [QAW-1:0]     r_rptr;
    logic [QCW-1:0]     r_count;
    logic [QCW-1:0]     n_count;

    // occupancy
    always_comb begin
        n_count = r_count;
        if (i_word.valid && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_word.valid && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    // pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_word.valid) begin
                r_wptr <= (r_wptr == QAW'(QUEUE_DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= (r_rptr == QAW'(QUEUE_DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            r_count <= n_count;
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (i_word.valid) begin
            r_q[r_wptr] <= i_word.sample;
        end
    end

    assign o_sample       = r_q[r_rptr];
    assign o_status.count = r_count;
    assign o_status.empty = (r_count == '0);

endmodule

`default_nettype wire
